// ----- rtl/core/kmc_pkg.sv -----
// kmc_pkg: shared types, codes and sizes of the rgb k-means clustering block
`default_nettype none
package kmc_pkg;

   localparam int MAX_COLORS_DEF   = 1024;
   localparam int MAX_CLUSTERS_DEF = 16;
   localparam int OUT_LIMIT        = 16;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_RUN   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [1:0] REG_NUM_CLUSTERS   = 2'd0;
   localparam logic [1:0] REG_EPSILON        = 2'd1;
   localparam logic [1:0] REG_MAX_ITERATIONS = 2'd2;
   localparam logic [1:0] REG_RANDOM_SEED    = 2'd3;

   localparam logic [15:0] LFSR_TAPS = 16'hB400;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [3:0]  cluster_index;
      logic [15:0] red_mean;
      logic [15:0] green_mean;
      logic [15:0] blue_mean;
      logic [7:0]  passes_done;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED,
      ST_PASS,
      ST_FETCH,
      ST_DIST,
      ST_ASSIGN,
      ST_UPD,
      ST_UDIV,
      ST_CHECK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic run_init;
      logic seed_step;
      logic pass_init;
      logic dist_step;
      logic assign_color;
      logic cnt_clear;
      logic div_start;
      logic upd_write;
      logic emit_next;
   } cmd_type;

   typedef struct packed {
      logic ch_last;
      logic cc_last;
      logic ci_last;
      logic store_empty;
      logic cluster_empty;
      logic stop;
      logic div_done;
   } status_type;

endpackage
`default_nettype wire

// ----- rtl/core/kmc_ram.sv -----
// kmc_ram: generic single write port ram with registered read
`default_nettype none
module kmc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

// ----- rtl/core/kmc_div.sv -----
// kmc_div: restoring divider, one quotient bit per cycle, 16-bit quotient
`default_nettype none
module kmc_div #(
   parameter int CNT_W = 11,
   localparam int DW = CNT_W + 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DW-1:0]    dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output logic                  done,
   output logic      [15:0]      quotient
);

   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [15:0]      quo_ff, quo_in;
   logic [3:0]       step_ff, step_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W:0]   trial;
   logic [CNT_W:0]   diff;

   assign trial = {rem_ff, quo_ff[15]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[DW-1:16];
         quo_in  = dividend[15:0];
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[CNT_W-1:0];
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[14:0], 1'b0};
         end
         step_in = step_ff + 4'd1;
         if (step_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ----- rtl/core/kmc_ctrl.sv -----
// kmc_ctrl: sequencing state machine of the clustering block
`default_nettype none
module kmc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [1:0]          req_func,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire kmc_pkg::status_type status,
   output kmc_pkg::cmd_type         cmd
);

   kmc_pkg::state_type state_ff, state_in;
   logic               cc_done;

   assign cc_done = status.ch_last && status.cc_last;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kmc_pkg::ST_IDLE: begin
            if (req_valid && req_func == kmc_pkg::FUNC_RUN) begin
               state_in = kmc_pkg::ST_SEED;
            end
         end
         kmc_pkg::ST_SEED: begin
            if (cc_done) begin
               state_in = kmc_pkg::ST_PASS;
            end
         end
         kmc_pkg::ST_PASS: begin
            state_in = status.store_empty ? kmc_pkg::ST_UPD : kmc_pkg::ST_FETCH;
         end
         kmc_pkg::ST_FETCH: begin
            state_in = kmc_pkg::ST_DIST;
         end
         kmc_pkg::ST_DIST: begin
            if (cc_done) begin
               state_in = kmc_pkg::ST_ASSIGN;
            end
         end
         kmc_pkg::ST_ASSIGN: begin
            state_in = status.ci_last ? kmc_pkg::ST_UPD : kmc_pkg::ST_FETCH;
         end
         kmc_pkg::ST_UPD: begin
            if (status.cluster_empty) begin
               if (cc_done) begin
                  state_in = kmc_pkg::ST_CHECK;
               end
            end else begin
               state_in = kmc_pkg::ST_UDIV;
            end
         end
         kmc_pkg::ST_UDIV: begin
            if (status.div_done) begin
               state_in = cc_done ? kmc_pkg::ST_CHECK : kmc_pkg::ST_UPD;
            end
         end
         kmc_pkg::ST_CHECK: begin
            state_in = status.stop ? kmc_pkg::ST_EMIT : kmc_pkg::ST_PASS;
         end
         kmc_pkg::ST_EMIT: begin
            if (rsp_ready && status.cc_last) begin
               state_in = kmc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kmc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         kmc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load     = (req_func == kmc_pkg::FUNC_LOAD);
               cmd.clear    = (req_func == kmc_pkg::FUNC_CLEAR);
               cmd.run_init = (req_func == kmc_pkg::FUNC_RUN);
            end
         end
         kmc_pkg::ST_SEED: begin
            cmd.seed_step = 1'b1;
         end
         kmc_pkg::ST_PASS: begin
            cmd.pass_init = 1'b1;
         end
         kmc_pkg::ST_DIST: begin
            cmd.dist_step = 1'b1;
         end
         kmc_pkg::ST_ASSIGN: begin
            cmd.assign_color = 1'b1;
            cmd.cnt_clear    = status.ci_last;
         end
         kmc_pkg::ST_UPD: begin
            cmd.upd_write = status.cluster_empty;
            cmd.div_start = !status.cluster_empty;
         end
         kmc_pkg::ST_UDIV: begin
            cmd.upd_write = status.div_done;
         end
         kmc_pkg::ST_CHECK: begin
            cmd.cnt_clear = 1'b1;
         end
         kmc_pkg::ST_EMIT: begin
            rsp_valid     = 1'b1;
            cmd.emit_next = rsp_ready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kmc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/kmc_datapath.sv -----
// kmc_datapath: color store, centroids, sums, lfsr, distance and update logic
`default_nettype none
module kmc_datapath #(
   parameter int MAX_COLORS   = kmc_pkg::MAX_COLORS_DEF,
   parameter int MAX_CLUSTERS = kmc_pkg::MAX_CLUSTERS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire kmc_pkg::cmd_type cmd,
   input  wire kmc_pkg::req_type req_payload,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_wdata,
   output kmc_pkg::status_type   status,
   output kmc_pkg::rsp_type      rsp_payload
);

   localparam int KLIM  = (MAX_CLUSTERS < kmc_pkg::OUT_LIMIT) ? MAX_CLUSTERS
                                                              : kmc_pkg::OUT_LIMIT;
   localparam int CI_W  = $clog2(KLIM);
   localparam int KC_W  = $clog2(KLIM + 1);
   localparam int CNT_W = $clog2(MAX_COLORS + 1);
   localparam int AW    = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
   localparam int SUM_W = CNT_W + 8;
   localparam int DW    = CNT_W + 16;

   logic [4:0]  nc_ff, nc_in;
   logic [15:0] eps_ff, eps_in;
   logic [7:0]  maxit_ff, maxit_in;
   logic [15:0] seed_ff, seed_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ci_ff, ci_in;
   logic [KC_W-1:0]  cc_ff, cc_in;
   logic [1:0]       ch_ff, ch_in;
   logic [7:0]       pass_ff, pass_in;
   logic [15:0]      lfsr_ff, lfsr_in;
   logic             moved_ff, moved_in;
   logic [33:0]      acc_ff, acc_in;
   logic [33:0]      best_ff, best_in;
   logic [CI_W-1:0]  pick_ff, pick_in;

   logic [15:0]      cent_ff [KLIM][3];
   logic [15:0]      cent_in [KLIM][3];
   logic [15:0]      prev_ff [KLIM][3];
   logic [15:0]      prev_in [KLIM][3];
   logic [SUM_W-1:0] sum_ff  [KLIM][3];
   logic [SUM_W-1:0] sum_in  [KLIM][3];
   logic [CNT_W-1:0] mem_ff  [KLIM];
   logic [CNT_W-1:0] mem_in  [KLIM];

   logic [KC_W-1:0]  k_val;
   logic [CI_W-1:0]  cx;
   logic [15:0]      lfsr_next;
   logic [23:0]      color;
   logic [7:0]       col_ch;
   logic [15:0]      cent_sel;
   logic signed [16:0] diff;
   logic [15:0]      mag;
   logic [31:0]      sq_full;
   logic [33:0]      dsum;
   logic [15:0]      new_val;
   logic [15:0]      prev_sel;
   logic [15:0]      delta;
   logic [DW-1:0]    dividend;
   logic             div_done;
   logic [15:0]      div_q;
   logic             full;
   logic [CNT_W-1:0] ci_next;

   kmc_ram #(
      .WIDTH (24),
      .DEPTH (MAX_COLORS)
   ) u_color_ram (
      .clock (clock),
      .we    (cmd.load && !full),
      .waddr (count_ff[AW-1:0]),
      .wdata ({req_payload.red_in, req_payload.green_in, req_payload.blue_in}),
      .raddr (ci_ff[AW-1:0]),
      .rdata (color)
   );

   kmc_div #(
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (mem_ff[cx]),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      if (nc_ff == 5'd0) begin
         k_val = KC_W'(1);
      end else if ({1'b0, nc_ff} > 6'(KLIM)) begin
         k_val = KC_W'(KLIM);
      end else begin
         k_val = KC_W'(nc_ff);
      end
   end

   assign cx        = cc_ff[CI_W-1:0];
   assign lfsr_next = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? kmc_pkg::LFSR_TAPS : 16'h0000);
   assign full      = (count_ff == CNT_W'(MAX_COLORS));
   assign ci_next   = ci_ff + CNT_W'(1);

   always_comb begin
      case (ch_ff)
         2'd0:    col_ch = color[23:16];
         2'd1:    col_ch = color[15:8];
         default: col_ch = color[7:0];
      endcase
   end

   assign cent_sel = cent_ff[cx][ch_ff];
   assign prev_sel = prev_ff[cx][ch_ff];
   assign diff     = $signed({1'b0, col_ch, 8'h00}) - $signed({1'b0, cent_sel});
   assign mag      = diff[16] ? 16'(-diff) : diff[15:0];
   assign sq_full  = 32'(mag) * 32'(mag);
   assign dsum     = acc_ff + {2'b00, sq_full};
   assign dividend = {sum_ff[cx][ch_ff], 8'h00} + DW'(mem_ff[cx] >> 1);
   assign new_val  = (mem_ff[cx] == '0) ? lfsr_next : div_q;
   assign delta    = (prev_sel > new_val) ? prev_sel - new_val : new_val - prev_sel;

   always_comb begin
      nc_in    = nc_ff;
      eps_in   = eps_ff;
      maxit_in = maxit_ff;
      seed_in  = seed_ff;
      count_in = count_ff;
      ci_in    = ci_ff;
      cc_in    = cc_ff;
      ch_in    = ch_ff;
      pass_in  = pass_ff;
      lfsr_in  = lfsr_ff;
      moved_in = moved_ff;
      acc_in   = acc_ff;
      best_in  = best_ff;
      pick_in  = pick_ff;
      cent_in  = cent_ff;
      prev_in  = prev_ff;
      sum_in   = sum_ff;
      mem_in   = mem_ff;

      if (csr_we) begin
         case (csr_index)
            kmc_pkg::REG_NUM_CLUSTERS:   nc_in    = csr_wdata[4:0];
            kmc_pkg::REG_EPSILON:        eps_in   = csr_wdata;
            kmc_pkg::REG_MAX_ITERATIONS: maxit_in = csr_wdata[7:0];
            kmc_pkg::REG_RANDOM_SEED:    seed_in  = csr_wdata;
            default:                     nc_in    = nc_ff;
         endcase
      end

      if (cmd.load && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.clear) begin
         count_in = '0;
      end

      if (cmd.run_init) begin
         lfsr_in = (seed_ff == 16'h0000) ? 16'h0001 : seed_ff;
         cc_in   = '0;
         ch_in   = '0;
         pass_in = '0;
      end

      if (cmd.seed_step || cmd.upd_write) begin
         if (cmd.seed_step || mem_ff[cx] == '0) begin
            lfsr_in = lfsr_next;
         end
         cent_in[cx][ch_ff] = cmd.seed_step ? lfsr_next : new_val;
         if (cmd.upd_write && delta > eps_ff) begin
            moved_in = 1'b1;
         end
         if (ch_ff == 2'd2) begin
            ch_in = '0;
            cc_in = cc_ff + KC_W'(1);
         end else begin
            ch_in = ch_ff + 2'd1;
         end
      end

      if (cmd.pass_init) begin
         prev_in  = cent_ff;
         pass_in  = pass_ff + 8'd1;
         ci_in    = '0;
         cc_in    = '0;
         ch_in    = '0;
         moved_in = 1'b0;
         acc_in   = '0;
         for (int c = 0; c < KLIM; c++) begin
            mem_in[c] = '0;
            for (int h = 0; h < 3; h++) begin
               sum_in[c][h] = '0;
            end
         end
      end

      if (cmd.dist_step) begin
         if (ch_ff == 2'd2) begin
            if (cc_ff == '0 || dsum < best_ff) begin
               best_in = dsum;
               pick_in = cx;
            end
            acc_in = '0;
            ch_in  = '0;
            cc_in  = cc_ff + KC_W'(1);
         end else begin
            acc_in = dsum;
            ch_in  = ch_ff + 2'd1;
         end
      end

      if (cmd.assign_color) begin
         mem_in[pick_ff]    = mem_ff[pick_ff] + CNT_W'(1);
         sum_in[pick_ff][0] = sum_ff[pick_ff][0] + SUM_W'(color[23:16]);
         sum_in[pick_ff][1] = sum_ff[pick_ff][1] + SUM_W'(color[15:8]);
         sum_in[pick_ff][2] = sum_ff[pick_ff][2] + SUM_W'(color[7:0]);
         ci_in = ci_next;
         cc_in = '0;
      end

      if (cmd.cnt_clear) begin
         cc_in = '0;
         ch_in = '0;
      end

      if (cmd.emit_next) begin
         cc_in = cc_ff + KC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nc_ff    <= 5'd6;
         eps_ff   <= 16'd128;
         maxit_ff <= 8'd20;
         seed_ff  <= 16'd1;
         count_ff <= '0;
         pass_ff  <= '0;
         lfsr_ff  <= 16'd1;
         ci_ff    <= '0;
         cc_ff    <= '0;
         ch_ff    <= '0;
         moved_ff <= 1'b0;
      end else begin
         nc_ff    <= nc_in;
         eps_ff   <= eps_in;
         maxit_ff <= maxit_in;
         seed_ff  <= seed_in;
         count_ff <= count_in;
         pass_ff  <= pass_in;
         lfsr_ff  <= lfsr_in;
         ci_ff    <= ci_in;
         cc_ff    <= cc_in;
         ch_ff    <= ch_in;
         moved_ff <= moved_in;
      end
      acc_ff  <= acc_in;
      best_ff <= best_in;
      pick_ff <= pick_in;
      cent_ff <= cent_in;
      prev_ff <= prev_in;
      sum_ff  <= sum_in;
      mem_ff  <= mem_in;
   end

   assign status.ch_last       = (ch_ff == 2'd2);
   assign status.cc_last       = (cc_ff == k_val - KC_W'(1));
   assign status.ci_last       = (ci_next == count_ff);
   assign status.store_empty   = (count_ff == '0);
   assign status.cluster_empty = (mem_ff[cx] == '0);
   assign status.stop          = (pass_ff >= maxit_ff) || !moved_ff;
   assign status.div_done      = div_done;

   assign rsp_payload.cluster_index = 4'(cx);
   assign rsp_payload.red_mean      = cent_ff[cx][0];
   assign rsp_payload.green_mean    = cent_ff[cx][1];
   assign rsp_payload.blue_mean     = cent_ff[cx][2];
   assign rsp_payload.passes_done   = pass_ff;
   assign rsp_payload.last_of_run   = (cc_ff == k_val - KC_W'(1));

endmodule
`default_nettype wire

// ----- rtl/core/rgb_kmeans_cluster.sv -----
// rgb_kmeans_cluster: top level of the lloyd k-means rgb color clusterer
// Load and clear transactions are taken in the idle state, so colors stream in one per
// cycle. A run transaction seeds k centroids from the lfsr, then each pass makes
// a labeling sweep over the N stored colors, one channel product per cycle
// through a single multiplier, then updates each channel of a non-empty cluster
// through the serial 16-bit divider and reseeds each channel of an empty one from
// the lfsr, and ends with a convergence check.
// The run then presents k results, one per cycle while rsp_ready is high.
// No new transaction is taken until the last result of a run has been taken.
`default_nettype none
module rgb_kmeans_cluster #(
   parameter int MAX_COLORS   = kmc_pkg::MAX_COLORS_DEF,
   parameter int MAX_CLUSTERS = kmc_pkg::MAX_CLUSTERS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire kmc_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output kmc_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_wdata
);

   kmc_pkg::cmd_type    cmd;
   kmc_pkg::status_type status;

   kmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_payload.func),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kmc_datapath #(
      .MAX_COLORS   (MAX_COLORS),
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ----- dv/tb_rgb_kmeans_cluster.sv -----
// tb_rgb_kmeans_cluster: self-checking testbench with predictor and scoreboard for the clusterer
`timescale 1ns / 1ps
module tb_rgb_kmeans_cluster;

   localparam int STALL_LIMIT = 2000000;
   localparam int HOLD_LENGTH = 400;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   class cluster_scoreboard;
      logic [4:0]  num_clusters;
      logic [15:0] epsilon;
      logic [7:0]  max_iterations;
      logic [15:0] random_seed;
      logic [23:0] colors[kmc_pkg::MAX_COLORS_DEF];
      int          color_count;
      logic [15:0] lfsr;
      logic [15:0] centroid[kmc_pkg::MAX_CLUSTERS_DEF][3];
      logic [15:0] prior[kmc_pkg::MAX_CLUSTERS_DEF][3];
      logic [3:0]  labels[kmc_pkg::MAX_COLORS_DEF];
      kmc_pkg::rsp_type expected_centroids[$];
      int          errors;

      function new();
         num_clusters = 6;
         epsilon = 128;
         max_iterations = 20;
         random_seed = 1;
         color_count = 0;
         lfsr = 1;
         errors = 0;
      endfunction

      function void write_register(logic [1:0] index, logic [15:0] value);
         case (index)
            kmc_pkg::REG_NUM_CLUSTERS:   num_clusters = value[4:0];
            kmc_pkg::REG_EPSILON:        epsilon = value;
            kmc_pkg::REG_MAX_ITERATIONS: max_iterations = value[7:0];
            kmc_pkg::REG_RANDOM_SEED:    random_seed = value;
            default: ;
         endcase
      endfunction

      function logic [15:0] step_lfsr();
         logic low;
         low = lfsr[0];
         lfsr = lfsr >> 1;
         if (low) lfsr = lfsr ^ kmc_pkg::LFSR_TAPS;
         return lfsr;
      endfunction

      function longint channel(logic [23:0] packed_color, int ch);
         return longint'(packed_color[23 - 8 * ch -: 8]);
      endfunction

      function void cluster_colors();
         int      k, passes, pick;
         longint  best, sq_dist, diff, n;
         longint  sums[kmc_pkg::MAX_CLUSTERS_DEF][3];
         longint  members[kmc_pkg::MAX_CLUSTERS_DEF];
         bit      shifted;
         kmc_pkg::rsp_type r;
         k = (num_clusters == 0) ? 1 : num_clusters;
         if (k > kmc_pkg::MAX_CLUSTERS_DEF) k = kmc_pkg::MAX_CLUSTERS_DEF;
         lfsr = (random_seed == 0) ? 16'd1 : random_seed;
         for (int c = 0; c < k; c++)
            for (int ch = 0; ch < 3; ch++) centroid[c][ch] = step_lfsr();
         passes = 0;
         forever begin
            prior = centroid;
            passes++;
            for (int i = 0; i < color_count; i++) begin
               best = 0;
               pick = 0;
               for (int c = 0; c < k; c++) begin
                  sq_dist = 0;
                  for (int ch = 0; ch < 3; ch++) begin
                     diff = (channel(colors[i], ch) << 8) - longint'(centroid[c][ch]);
                     sq_dist += diff * diff;
                  end
                  if (c == 0 || sq_dist < best) begin
                     best = sq_dist;
                     pick = c;
                  end
               end
               labels[i] = 4'(pick);
            end
            for (int c = 0; c < k; c++) begin
               members[c] = 0;
               for (int ch = 0; ch < 3; ch++) sums[c][ch] = 0;
            end
            for (int i = 0; i < color_count; i++) begin
               members[labels[i]]++;
               for (int ch = 0; ch < 3; ch++) sums[labels[i]][ch] += channel(colors[i], ch);
            end
            for (int c = 0; c < k; c++) begin
               n = members[c];
               for (int ch = 0; ch < 3; ch++)
                  if (n == 0) centroid[c][ch] = step_lfsr();
                  else centroid[c][ch] = 16'(((sums[c][ch] << 8) + n / 2) / n);
            end
            shifted = 0;
            for (int c = 0; c < k; c++)
               for (int ch = 0; ch < 3; ch++)
                  if ((prior[c][ch] > centroid[c][ch] ? prior[c][ch] - centroid[c][ch]
                       : centroid[c][ch] - prior[c][ch]) > epsilon) shifted = 1;
            if (passes >= max_iterations || !shifted) break;
         end
         for (int c = 0; c < k; c++) begin
            r.cluster_index = 4'(c);
            r.red_mean = centroid[c][0];
            r.green_mean = centroid[c][1];
            r.blue_mean = centroid[c][2];
            r.passes_done = 8'(passes);
            r.last_of_run = (c + 1 == k);
            expected_centroids.push_back(r);
         end
      endfunction

      function void note_request(kmc_pkg::req_type t);
         case (t.func)
            kmc_pkg::FUNC_LOAD:
               if (color_count < kmc_pkg::MAX_COLORS_DEF) begin
                  colors[color_count] = {t.red_in, t.green_in, t.blue_in};
                  color_count++;
               end
            kmc_pkg::FUNC_CLEAR: color_count = 0;
            kmc_pkg::FUNC_RUN:   cluster_colors();
            default: ;
         endcase
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $display("%0t mismatch %s expected %0h actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(kmc_pkg::rsp_type got);
         kmc_pkg::rsp_type want;
         if (expected_centroids.size() == 0) begin
            $display("%0t unexpected result expected none actual %p", $time, got);
            errors++;
            return;
         end
         want = expected_centroids.pop_front();
         check_field("cluster_index", 16'(want.cluster_index), 16'(got.cluster_index));
         check_field("red_mean", want.red_mean, got.red_mean);
         check_field("green_mean", want.green_mean, got.green_mean);
         check_field("blue_mean", want.blue_mean, got.blue_mean);
         check_field("passes_done", 16'(want.passes_done), 16'(got.passes_done));
         check_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   kmc_pkg::req_type req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   kmc_pkg::rsp_type rsp_payload;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   cluster_scoreboard board;
   int send_idle_pct;
   int recv_stall_pct;
   logic long_hold;
   logic hold_taken;
   int hold_cycles;
   int quiet_cycles;

   rgb_kmeans_cluster dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // result side: random stalls and one long hold-off once results are waiting
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         hold_cycles <= 0;
         hold_taken <= 0;
      end else if (long_hold && !hold_taken && rsp_valid) begin
         rsp_ready <= 0;
         hold_cycles <= HOLD_LENGTH;
         hold_taken <= 1;
      end else if (hold_cycles > 0) begin
         rsp_ready <= 0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) board.check_response(rsp_payload);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic send_transaction(kmc_pkg::req_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_payload <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(t);
   endtask

   task automatic send_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      kmc_pkg::req_type t;
      t.func = kmc_pkg::FUNC_LOAD;
      t.red_in = r;
      t.green_in = g;
      t.blue_in = b;
      send_transaction(t);
   endtask

   task automatic send_random_color();
      send_color(8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic send_func(logic [1:0] f);
      kmc_pkg::req_type t;
      t.func = f;
      t.red_in = 8'($urandom);
      t.green_in = 8'($urandom);
      t.blue_in = 8'($urandom);
      send_transaction(t);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (board.expected_centroids.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [15:0] value);
      csr_we <= 1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.write_register(index, value);
      csr_we <= 0;
   endtask

   task automatic set_config(logic [4:0] k, logic [15:0] eps, logic [7:0] iters,
                             logic [15:0] seed);
      drain();
      write_csr(kmc_pkg::REG_NUM_CLUSTERS, 16'(k));
      write_csr(kmc_pkg::REG_EPSILON, eps);
      write_csr(kmc_pkg::REG_MAX_ITERATIONS, 16'(iters));
      write_csr(kmc_pkg::REG_RANDOM_SEED, seed);
   endtask

   task automatic random_sequence(int max_colors);
      int n;
      if ($urandom_range(3) == 0) send_func(kmc_pkg::FUNC_CLEAR);
      n = $urandom_range(max_colors);
      repeat (n) begin
         if ($urandom_range(15) == 0) send_func(FUNC_UNUSED);
         send_random_color();
      end
      send_func(kmc_pkg::FUNC_RUN);
   endtask

   initial begin
      board = new();
      reset <= 1;
      req_valid <= 0;
      req_payload <= '0;
      csr_we <= 0;
      csr_index <= kmc_pkg::REG_NUM_CLUSTERS;
      csr_wdata <= '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      long_hold = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset settings, empty store, extreme colors, unused func
      send_func(kmc_pkg::FUNC_RUN);
      send_color(8'd0, 8'd0, 8'd0);
      send_color(8'd255, 8'd255, 8'd255);
      send_color(8'd255, 8'd0, 8'd0);
      send_color(8'd0, 8'd255, 8'd0);
      send_color(8'd0, 8'd0, 8'd255);
      send_color(8'd255, 8'd255, 8'd255);
      send_func(FUNC_UNUSED);
      send_func(kmc_pkg::FUNC_RUN);
      send_func(kmc_pkg::FUNC_CLEAR);
      send_func(kmc_pkg::FUNC_RUN);
      send_color(8'd128, 8'd128, 8'd128);
      send_color(8'd128, 8'd128, 8'd128);

      set_config(5'd0, 16'd0, 8'd0, 16'd0);
      send_func(kmc_pkg::FUNC_RUN);
      set_config(5'd31, 16'hFFFF, 8'd1, 16'hFFFF);
      send_func(kmc_pkg::FUNC_RUN);
      send_color(8'd10, 8'd200, 8'd30);
      set_config(5'd16, 16'd0, 8'd255, 16'h8001);
      send_color(8'd240, 8'd20, 8'd90);
      send_func(kmc_pkg::FUNC_RUN);
      set_config(5'd1, 16'hFFFF, 8'd255, 16'd1);
      send_func(kmc_pkg::FUNC_RUN);

      // two clusters, single pass over a fresh store
      set_config(5'd2, 16'd128, 8'd1, 16'h1234);
      send_func(kmc_pkg::FUNC_CLEAR);
      repeat (20) send_random_color();
      send_func(kmc_pkg::FUNC_RUN);
      send_func(kmc_pkg::FUNC_CLEAR);

      for (int phase = 0; phase < 10; phase++) begin
         set_config(5'(($urandom_range(7) == 0) ? $urandom_range(31)
                                                : $urandom_range(1, 16)),
                    16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(1023)),
                    8'($urandom_range(10)),
                    ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom));
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         if (phase == 2) begin
            long_hold = 1;
            send_func(kmc_pkg::FUNC_RUN);
            repeat (6) send_random_color();
         end
         repeat (4) random_sequence(12);
      end

      drain();
      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.expected_centroids.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
